>>> rtl/core/jsu_pkg.sv
// shared types and constants for the json string unescape block
package jsu_pkg;

  localparam int JSU_FIFO_DEPTH = 4;
  localparam int JSU_PTR_W      = $clog2(JSU_FIFO_DEPTH);

  // status codes of a result
  localparam logic [2:0] ST_BYTE    = 3'd0;
  localparam logic [2:0] ST_CLOSED  = 3'd1;
  localparam logic [2:0] ST_NOQUOTE = 3'd2;
  localparam logic [2:0] ST_CTRL    = 3'd3;
  localparam logic [2:0] ST_BADESC  = 3'd4;
  localparam logic [2:0] ST_BADHEX  = 3'd5;
  localparam logic [2:0] ST_UNTERM  = 3'd6;

  // results caused by one input byte; cnt is 1 to 3
  typedef struct packed {
    logic [1:0] cnt;
    logic [2:0] status;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } run_t;

endpackage

>>> rtl/core/jsu_front.sv
// front end: string state machine, escape and utf-8 encoding
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_text_byte,
  output logic       push,
  output run_t       push_run
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] accum_r, accum_nxt;

  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] cp;
  logic [7:0]  c;
  run_t        run;

  assign c = in_text_byte;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_d = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_d = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp = {accum_r[11:0], hex_d};

  always_comb begin
    phase_nxt   = phase_r;
    hex_cnt_nxt = hex_cnt_r;
    accum_nxt   = accum_r;
    run         = '{cnt: 2'd0, status: ST_BYTE, b0: 8'h00, b1: 8'h00, b2: 8'h00};
    case (phase_r)
      PH_STR: begin
        if (c == 8'h22) begin
          run.cnt = 2'd1; run.status = ST_CLOSED; phase_nxt = PH_IDLE;
        end else if (c == 8'h00) begin
          run.cnt = 2'd1; run.status = ST_UNTERM; phase_nxt = PH_IDLE;
        end else if (c < 8'h20) begin
          run.cnt = 2'd1; run.status = ST_CTRL; phase_nxt = PH_IDLE;
        end else if (c == 8'h5c) begin
          phase_nxt = PH_ESC;
        end else begin
          run.cnt = 2'd1; run.b0 = c;
        end
      end
      PH_ESC: begin
        run.cnt   = 2'd1;
        phase_nxt = PH_STR;
        case (c)
          8'h22, 8'h5c, 8'h2f: run.b0 = c;
          8'h62: run.b0 = 8'h08;
          8'h66: run.b0 = 8'h0c;
          8'h6e: run.b0 = 8'h0a;
          8'h72: run.b0 = 8'h0d;
          8'h74: run.b0 = 8'h09;
          8'h75: begin
            run.cnt     = 2'd0;
            phase_nxt   = PH_HEX;
            hex_cnt_nxt = 2'd0;
            accum_nxt   = 16'h0000;
          end
          default: begin
            run.status = ST_BADESC;
            phase_nxt  = PH_IDLE;
          end
        endcase
      end
      PH_HEX: begin
        if (!hex_ok) begin
          run.cnt     = 2'd1;
          run.status  = ST_BADHEX;
          phase_nxt   = PH_IDLE;
          hex_cnt_nxt = 2'd0;
          accum_nxt   = 16'h0000;
        end else begin
          accum_nxt = cp;
          if (hex_cnt_r == 2'd3) begin
            phase_nxt   = PH_STR;
            hex_cnt_nxt = 2'd0;
            if (cp <= 16'h007f) begin
              run.cnt = 2'd1;
              run.b0  = cp[7:0];
            end else if (cp <= 16'h07ff) begin
              run.cnt = 2'd2;
              run.b0  = 8'hc0 | {3'b000, cp[10:6]};
              run.b1  = 8'h80 | {2'b00, cp[5:0]};
            end else begin
              run.cnt = 2'd3;
              run.b0  = 8'he0 | {4'h0, cp[15:12]};
              run.b1  = 8'h80 | {2'b00, cp[11:6]};
              run.b2  = 8'h80 | {2'b00, cp[5:0]};
            end
          end else begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end
        end
      end
      default: begin
        if (c == 8'h22) begin
          phase_nxt = PH_STR;
        end else if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0d))) begin
          run.cnt = 2'd1; run.status = ST_NOQUOTE; phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  assign push     = in_fire && (run.cnt != 2'd0);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hex_cnt_r <= 2'd0;
      accum_r   <= 16'h0000;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      accum_r   <= accum_nxt;
    end
  end

endmodule

>>> rtl/core/jsu_fifo.sv
// short queue of result runs between front and back
module jsu_fifo import jsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  run_t push_run,
  input  logic pop,
  output run_t pop_run,
  output logic full,
  output logic empty
);

  run_t                 mem_r [JSU_FIFO_DEPTH];
  logic [JSU_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JSU_PTR_W:0]   count_r;

  assign full    = (count_r == (JSU_PTR_W+1)'(JSU_FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_run = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/core/jsu_back.sv
// back end: splits a run into single results on the output channel
module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fifo_empty,
  input  run_t       fifo_run,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [2:0] out_status,
  output logic       out_last_of_run
);

  run_t       cur_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       last;
  logic       out_fire;

  assign last     = (idx_r == cur_r.cnt - 2'd1);
  assign out_fire = busy_r && !out_stall;
  assign pop      = !fifo_empty && (!busy_r || (out_fire && last));

  assign out_valid       = busy_r;
  assign out_status      = cur_r.status;
  assign out_last_of_run = last;

  always_comb begin
    case (idx_r)
      2'd0:    out_out_byte = cur_r.b0;
      2'd1:    out_out_byte = cur_r.b1;
      default: out_out_byte = cur_r.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= fifo_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (out_fire) begin
      if (last) begin
        busy_r <= 1'b0;
        idx_r  <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/json_string_unescape.sv
// top level of the json string unescaper: front end, run queue and back end
// each run is written into the run queue, then loaded into the back end's run register
// throughput: one text byte per cycle in unless the queue is full, one result per cycle
//   out unless out_stall; a \uXXXX escape that ends in three utf-8 bytes is a run of three results
// the four-entry run queue sets how long the input keeps going under out_stall
// reset (rst_n low, synchronous): parser idle awaiting a quote, queue and output empty
module json_string_unescape import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // text input, one byte per transaction
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  // decoded results, one per transaction
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [2:0] out_status,
  output logic       out_last_of_run
);

  logic in_fire;
  logic push;
  run_t push_run;
  logic pop;
  run_t pop_run;
  logic full;
  logic empty;

  // the front may only step while the queue has room for its run
  assign in_stall = full;
  assign in_fire  = in_valid && !full;

  // front: phase tracking, escape mapping, hex gathering and utf-8 encoding
  jsu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_text_byte (in_text_byte),
    .push         (push),
    .push_run     (push_run)
  );

  // queue of runs of one to three results each
  jsu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .pop_run  (pop_run),
    .full     (full),
    .empty    (empty)
  );

  // back: one result per transaction, last_of_run on the final one of a run
  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_empty      (empty),
    .fifo_run        (pop_run),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> tb/tb_json_string_unescape.sv
// testbench for json_string_unescape: directed and random text checked against a decoder model
`timescale 1ns / 100ps

module tb_json_string_unescape;
  import jsu_pkg::*;

  // ascii codes the parser reacts to
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam int RANDOM_ITEMS   = 320;
  localparam int DRAIN_SPACING  = 100;  // text bytes between forced drain pauses
  localparam int TAIL_ITEMS     = 40;   // last stretch of text runs without idling
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  // decoder phase of the string parser
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_STRING = 3'd1,
    PH_ESCAPE = 3'd2,
    PH_HEX    = 3'd3
  } parse_phase_t;

  // one decoded result as it should leave the block
  typedef struct {
    logic [7:0] data;
    logic [2:0] status;
    logic       last;
  } result_t;

  // one text byte waiting to be sent; drain holds it back until all results are out
  typedef struct {
    logic [7:0] text;
    logic       drain;
  } text_item_t;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_out_byte;
  logic [2:0] out_status;
  logic       out_last_of_run;

  text_item_t text_q[$];     // text bytes not yet offered to the block
  result_t    decoded_q[$];  // decoded results still owed by the block

  // decoder model state
  parse_phase_t parse_phase = PH_IDLE;
  logic [1:0]   hex_taken   = 2'd0;
  logic [15:0]  code_point  = 16'h0000;

  int n_sent         = 0;  // text bytes put on the input port
  int n_taken        = 0;  // text bytes accepted by the block
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int in_gap_left    = 0;
  int stall_left     = 0;
  int mode_left      = 0;
  logic [1:0] idle_mode  = 2'd0;
  logic in_idle_on  = 1'b0;
  logic out_idle_on = 1'b0;

  json_string_unescape i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  function automatic result_t result_of(input logic [7:0] d, input logic [2:0] s);
    result_t r;
    r.data   = d;
    r.status = s;
    r.last   = 1'b0;
    return r;
  endfunction

  // value of a hex digit of either case, -1 for anything else
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // single-byte escapes; \u is handled on its own
  function automatic logic escape_byte(input logic [7:0] c, output logic [7:0] mapped);
    mapped = 8'h00;
    case (c)
      8'h22, 8'h5c, 8'h2f: mapped = c;
      8'h62: mapped = 8'h08;
      8'h66: mapped = 8'h0c;
      8'h6e: mapped = 8'h0a;
      8'h72: mapped = 8'h0d;
      8'h74: mapped = 8'h09;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // advance the parser by one text byte and queue the results it owes
  task automatic decode_text_byte(input logic [7:0] c);
    result_t    run[$];
    logic [7:0] mapped;
    int         digit;
    logic [15:0] cp;
    case (parse_phase)
      PH_STRING: begin
        if (c == CH_QUOTE) begin
          run.push_back(result_of(8'h00, ST_CLOSED));
          parse_phase = PH_IDLE;
        end else if (c == 8'h00) begin
          run.push_back(result_of(8'h00, ST_UNTERM));
          parse_phase = PH_IDLE;
        end else if (c < 8'h20) begin
          run.push_back(result_of(8'h00, ST_CTRL));
          parse_phase = PH_IDLE;
        end else if (c == CH_BSLASH) begin
          parse_phase = PH_ESCAPE;
        end else begin
          run.push_back(result_of(c, ST_BYTE));
        end
      end
      PH_ESCAPE: begin
        if (c == CH_U) begin
          parse_phase = PH_HEX;
          hex_taken   = 2'd0;
          code_point  = 16'h0000;
        end else if (escape_byte(c, mapped)) begin
          run.push_back(result_of(mapped, ST_BYTE));
          parse_phase = PH_STRING;
        end else begin
          run.push_back(result_of(8'h00, ST_BADESC));
          parse_phase = PH_IDLE;
        end
      end
      PH_HEX: begin
        digit = hex_digit(c);
        if (digit < 0) begin
          run.push_back(result_of(8'h00, ST_BADHEX));
          parse_phase = PH_IDLE;
          hex_taken   = 2'd0;
          code_point  = 16'h0000;
        end else begin
          code_point = {code_point[11:0], digit[3:0]};
          if (hex_taken == 2'd3) begin
            // utf-8 of the code point, surrogates encoded as they stand
            cp = code_point;
            if (cp <= 16'h007f) begin
              run.push_back(result_of(cp[7:0], ST_BYTE));
            end else if (cp <= 16'h07ff) begin
              run.push_back(result_of({3'b110, cp[10:6]}, ST_BYTE));
              run.push_back(result_of({2'b10, cp[5:0]}, ST_BYTE));
            end else begin
              run.push_back(result_of({4'b1110, cp[15:12]}, ST_BYTE));
              run.push_back(result_of({2'b10, cp[11:6]}, ST_BYTE));
              run.push_back(result_of({2'b10, cp[5:0]}, ST_BYTE));
            end
            parse_phase = PH_STRING;
            hex_taken   = 2'd0;
          end else begin
            hex_taken = hex_taken + 2'd1;
          end
        end
      end
      default: begin
        // idle: whitespace is skipped, a quote opens a string, anything else is an error
        if (c == CH_QUOTE) begin
          parse_phase = PH_STRING;
        end else if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0d))) begin
          run.push_back(result_of(8'h00, ST_NOQUOTE));
          parse_phase = PH_IDLE;
        end
      end
    endcase
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) decoded_q.push_back(run[i]);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] b, input logic drain = 1'b0);
    text_item_t t;
    t.text  = b;
    t.drain = drain;
    text_q.push_back(t);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin
    static logic [7:0]  esc_letters[8] =
      '{8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74};
    static logic [7:0]  ws_bytes[6]    = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    static logic [15:0] range_lo[4]    = '{16'h0000, 16'h0080, 16'h0800, 16'hd800};
    static logic [15:0] range_hi[4]    = '{16'h007f, 16'h07ff, 16'hffff, 16'hdfff};
    logic [7:0]  b;
    logic [7:0]  mapped;
    logic [15:0] cp;
    logic [3:0]  nib;
    int          directed_n;
    int          next_drain;
    int          n_parts;
    int          cut;
    int          cls;
    logic        broken;

    // directed: whitespace and a stray byte 0 while idle, top plain byte,
    // escaped quote, \u0000, a lone surrogate in mixed case, close, control byte,
    // unknown escape, bad hex digit and end of text inside a string
    add_byte(8'h20);
    add_byte(8'h00);
    add_byte(CH_QUOTE);
    add_byte(8'hff);
    add_text("\\\"");
    add_text("\\u0000");
    add_text("\\udFfF");
    add_byte(CH_QUOTE);
    add_byte(CH_QUOTE);
    add_byte(8'h1f);
    add_byte(CH_QUOTE);
    add_text("\\q");
    add_byte(CH_QUOTE);
    add_text("\\ug");
    add_byte(CH_QUOTE);
    add_byte(8'h00);
    directed_n = text_q.size();
    next_drain = directed_n;

    // random part: mostly well-formed strings, some broken ones and loose noise
    while (text_q.size() < directed_n + RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 2)) add_byte(ws_bytes[$urandom_range(0, 5)]);
        // opening quote; now and then the block must drain before it goes in
        add_byte(CH_QUOTE, text_q.size() >= next_drain);
        if (text_q.size() > next_drain) next_drain += DRAIN_SPACING;
        n_parts = $urandom_range(0, 6);
        broken  = ($urandom_range(0, 7) == 0);
        cut     = $urandom_range(0, n_parts);
        for (int k = 0; k < n_parts && !(broken && k == cut); k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              do b = 8'($urandom_range(8'h20, 8'hff));
              while (b == CH_QUOTE || b == CH_BSLASH);
              add_byte(b);
            end
            4, 5: begin
              add_byte(CH_BSLASH);
              add_byte(esc_letters[$urandom_range(0, 7)]);
            end
            default: begin
              // \uXXXX from one utf-8 length class, endpoints favored
              cls = $urandom_range(0, 3);
              cp  = 16'($urandom_range(range_lo[cls], range_hi[cls]));
              if ($urandom_range(0, 3) == 0)
                cp = $urandom_range(0, 1) ? range_lo[cls] : range_hi[cls];
              add_byte(CH_BSLASH);
              add_byte(CH_U);
              for (int j = 3; j >= 0; j--) begin
                nib = cp[j*4 +: 4];
                if (nib < 10) add_byte(8'h30 + nib);
                else add_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
              end
            end
          endcase
        end
        if (!broken) begin
          add_byte(CH_QUOTE);
        end else begin
          case ($urandom_range(0, 3))
            0: add_byte(8'($urandom_range(1, 31)));
            1: add_byte(8'h00);
            2: begin
              // escape letter that is neither a known escape nor u
              do b = 8'($urandom_range(0, 255));
              while (escape_byte(b, mapped) || b == CH_U);
              add_byte(CH_BSLASH);
              add_byte(b);
            end
            default: begin
              add_byte(CH_BSLASH);
              add_byte(CH_U);
              repeat ($urandom_range(0, 3)) add_byte(8'h30 + 8'($urandom_range(0, 9)));
              do b = 8'($urandom_range(0, 255));
              while (hex_digit(b) >= 0);
              add_byte(b);
            end
          endcase
        end
      end
    end

    // reset once
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // all text sent and accepted, then all results back
    do @(negedge clk); while (text_q.size() != 0 || in_valid);
    do @(negedge clk); while (decoded_q.size() != 0);
    // let the pipeline settle so a stray result would still show
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // idling control
  // ---------------------------------------------------------------------------

  // pick at random which sides may idle for a random stretch; the tail runs clean
  always @(negedge clk) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 80);
      idle_mode = 2'($urandom_range(0, 3));
    end else begin
      mode_left--;
    end
    in_idle_on  = idle_mode[0] && (text_q.size() >= TAIL_ITEMS);
    out_idle_on = idle_mode[1] && (text_q.size() >= TAIL_ITEMS);
  end

  // result side: stall in bursts of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // text driver
  // ---------------------------------------------------------------------------

  // a new byte goes out only once the previous transaction is done
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (text_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (text_q[0].drain && (n_taken != n_sent || decoded_q.size() != 0)) begin
        // hold back until every owed result has come out
        in_valid <= 1'b0;
      end else begin
        in_valid     <= 1'b1;
        in_text_byte <= text_q[0].text;
        text_q.pop_front();
        n_sent++;
        // while input idling is on, now and then a gap of random length after this byte
        if (in_idle_on && $urandom_range(0, 5) == 0) in_gap_left = $urandom_range(1, 15);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on input transactions, check on output transactions
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_text_byte(in_text_byte);
        n_taken++;
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          note_failure($sformatf("unexpected result: byte %02h status %0d last %0b",
                                 out_out_byte, out_status, out_last_of_run));
        end else begin
          want = decoded_q.pop_front();
          if (out_out_byte !== want.data || out_status !== want.status ||
              out_last_of_run !== want.last) begin
            note_failure($sformatf(
              {"mismatch: expected byte %02h status %0d last %0b, ",
               "got byte %02h status %0d last %0b"},
              want.data, want.status, want.last, out_out_byte, out_status, out_last_of_run));
          end
        end
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

endmodule

>>> files.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_fifo.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape.sv
tb/tb_json_string_unescape.sv
